>>> hdl/assert_macros.svh
// Assertion macros shared by the retry table modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clock, ignored while reset is high.
`define AERT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition implies another one in the same cycle.
`define AERT_IMPLY(lbl, cond, conseq, msg) \
   `AERT_ASSERT(lbl, (cond) |-> (conseq), msg)

`endif

>>> hdl/aert_pkg.sv
`default_nettype none

package aert_pkg;

   localparam int TABLE_SLOTS_DEF = 8;
   localparam int RETRY_LIMIT_DEF = 6;

   localparam int NOW_W    = 48;
   localparam int SEQ_W    = 32;
   localparam int CNT_W    = 32;
   localparam int NUM_CNT  = 5;
   localparam int DELAY_W  = 14;
   localparam int RETRY_W  = 3;

   localparam logic [NOW_W-1:0] NOW_MAX = '1;
   localparam logic [SEQ_W-1:0] SEQ_MAX = '1;
   localparam logic [SEQ_W-1:0] SEQ_FIRST = 32'd1;

   // Command codes
   localparam logic [2:0] CMD_SUBMIT  = 3'd0;
   localparam logic [2:0] CMD_TICK    = 3'd1;
   localparam logic [2:0] CMD_ACK     = 3'd2;
   localparam logic [2:0] CMD_CLEAR   = 3'd3;
   localparam logic [2:0] CMD_SENDERR = 3'd4;

   localparam logic KIND_DETECTED = 1'b0;
   localparam logic KIND_CLEARED  = 1'b1;

   // Result status codes
   localparam logic [2:0] RS_OK        = 3'd0;
   localparam logic [2:0] RS_INVALID   = 3'd1;
   localparam logic [2:0] RS_FULL      = 3'd2;
   localparam logic [2:0] RS_SEQ_EXH   = 3'd3;
   localparam logic [2:0] RS_ACK_MATCH = 3'd4;
   localparam logic [2:0] RS_ACK_MISS  = 3'd5;
   localparam logic [2:0] RS_DONE      = 3'd6;

   // Error counter indexes
   localparam logic [2:0] CNT_FULL    = 3'd0;
   localparam logic [2:0] CNT_RETRY   = 3'd1;
   localparam logic [2:0] CNT_SENDERR = 3'd2;
   localparam logic [2:0] CNT_UNCONF  = 3'd3;
   localparam logic [2:0] CNT_SEQEX   = 3'd4;

   // Configuration register indexes
   localparam logic REG_BOOT_ID    = 1'b0;
   localparam logic REG_LINK_READY = 1'b1;

   typedef enum logic [2:0] {
      OP_SUBMIT,
      OP_INVALID,
      OP_TICK,
      OP_ACK,
      OP_ACK_NOBOOT,
      OP_CLEAR,
      OP_SENDERR
   } op_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_EMIT,
      S_WAITRD,
      S_LOAD
   } state_type;

   typedef struct packed {
      op_type            op;
      logic              level;
      logic [NOW_W-1:0]  now;
      logic [SEQ_W-1:0]  ack_seq;
      logic [2:0]        sel;
   } job_type;

   typedef struct packed {
      logic [SEQ_W-1:0]   seq;
      logic               level;
      logic [NOW_W-1:0]   due;
      logic [RETRY_W-1:0] retries;
   } slot_type;

   typedef struct packed {
      logic               level;
      logic [SEQ_W-1:0]   seq;
   } pkt_type;

   typedef struct packed {
      logic              is_packet;
      logic [SEQ_W-1:0]  packet_sequence;
      logic              packet_level;
      logic [2:0]        status;
      logic [3:0]        pending_count;
      logic [NOW_W-1:0]  next_deadline;
      logic              level_valid;
      logic              level_now;
      logic [CNT_W-1:0]  counter_value;
      logic              last;
   } rsp_type;

   // Retry delay in milliseconds, doubling from 250 ms up to a cap of 8000 ms.
   function automatic logic [DELAY_W-1:0] delay_ms(input logic [RETRY_W-1:0] idx);
      logic [DELAY_W-1:0] d;
      case (idx)
         3'd0:    d = 14'd250;
         3'd1:    d = 14'd500;
         3'd2:    d = 14'd1000;
         3'd3:    d = 14'd2000;
         3'd4:    d = 14'd4000;
         default: d = 14'd8000;
      endcase
      return d;
   endfunction

   function automatic logic [NOW_W-1:0] due_after(input logic [NOW_W-1:0] now,
                                                  input logic [DELAY_W-1:0] dly);
      logic [NOW_W:0] sum;
      sum = {1'b0, now} + {{(NOW_W+1-DELAY_W){1'b0}}, dly};
      return sum[NOW_W] ? NOW_MAX : sum[NOW_W-1:0];
   endfunction

endpackage

`default_nettype wire

>>> hdl/aert_ram.sv
`default_nettype none

module aert_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> hdl/aert_front.sv
`default_nettype none
`include "assert_macros.svh"

module aert_front
   import aert_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [2:0]        cmd,
   input  wire logic              event_kind,
   input  wire logic              event_level,
   input  wire logic [NOW_W-1:0]  now_ms,
   input  wire logic [SEQ_W-1:0]  ack_boot_id,
   input  wire logic [SEQ_W-1:0]  ack_sequence,
   input  wire logic [2:0]        counter_select,
   input  wire logic [SEQ_W-1:0]  boot_id,
   input  wire logic              pop,
   output logic                   empty,
   output job_type                job
);

   job_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] q_cnt_ff, q_cnt_in;
   job_type    cls;
   logic       push;

   always_comb begin
      cls.level   = event_level;
      cls.now     = now_ms;
      cls.ack_seq = ack_sequence;
      cls.sel     = counter_select;
      case (cmd)
         CMD_SUBMIT: begin
            if ((event_kind == KIND_DETECTED && event_level) ||
                (event_kind == KIND_CLEARED && !event_level)) begin
               cls.op = OP_SUBMIT;
            end else begin
               cls.op = OP_INVALID;
            end
         end
         CMD_TICK:    cls.op = OP_TICK;
         CMD_ACK:     cls.op = (ack_boot_id == boot_id) ? OP_ACK : OP_ACK_NOBOOT;
         CMD_CLEAR:   cls.op = OP_CLEAR;
         CMD_SENDERR: cls.op = OP_SENDERR;
         default:     cls.op = OP_INVALID;
      endcase
   end

   assign req_tready = (q_cnt_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign empty      = (q_cnt_ff == 2'd0);
   assign job        = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      q_cnt_in  = q_cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         q_cnt_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         q_cnt_ff  <= q_cnt_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= cls;
      end
   end

   `AERT_ASSERT(a_q_bound, q_cnt_ff <= 2'd2, "queue count out of range")
   `AERT_IMPLY(a_no_pop_empty, pop, q_cnt_ff != 2'd0, "pop from empty queue")

endmodule

`default_nettype wire

>>> hdl/aert_back.sv
`default_nettype none
`include "assert_macros.svh"

module aert_back
   import aert_pkg::*;
#(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
   parameter int RETRY_LIMIT = RETRY_LIMIT_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    link_ready,
   input  wire logic    q_empty,
   input  job_type      q_job,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp
);

   localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CW = $clog2(TABLE_SLOTS + 1);
   localparam int SW = $bits(slot_type);
   localparam int PW = $bits(pkt_type);
   localparam logic [RETRY_W-1:0] LIMIT   = RETRY_W'(RETRY_LIMIT);
   localparam logic [RETRY_W-1:0] TOP_IDX = RETRY_W'(RETRY_LIMIT - 1);

   state_type        state_ff, state_in;
   job_type          job_ff, job_in;
   logic [TABLE_SLOTS-1:0] used_ff, used_in;
   logic [SEQ_W-1:0] next_seq_ff, next_seq_in;
   logic             seq_done_ff, seq_done_in;
   logic             lvl_valid_ff, lvl_valid_in;
   logic             lvl_ff, lvl_in;
   logic [CNT_W-1:0] err_ff [NUM_CNT];
   logic [CNT_W-1:0] err_in [NUM_CNT];
   logic [NUM_CNT-1:0] bump;
   logic [CW-1:0]    scan_ff, scan_in;
   logic             proc_vld_ff, proc_vld_in;
   logic [IW-1:0]    proc_idx_ff, proc_idx_in;
   logic [CW-1:0]    pend_ff, pend_in;
   logic [NOW_W-1:0] dl_ff, dl_in;
   logic             found_ff, found_in;
   logic [2:0]       status_ff, status_in;
   logic [SEQ_W-1:0] st_seq_ff, st_seq_in;
   logic             st_lvl_ff, st_lvl_in;
   logic [CW-1:0]    pkt_cnt_ff, pkt_cnt_in;
   logic [CW-1:0]    emit_idx_ff, emit_idx_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic             slot_we;
   logic [IW-1:0]    slot_waddr, slot_raddr;
   slot_type         slot_wdata, slot_rdata;
   logic [SW-1:0]    slot_rbits;
   logic             pkt_we;
   pkt_type          pkt_wdata, pkt_rdata;
   logic [PW-1:0]    pkt_rbits;

   logic             free_any;
   logic [IW-1:0]    free_idx;
   logic             out_free;
   logic [CW+3:0]    pend_ext;
   logic [RETRY_W-1:0] nr, ridx;
   logic [NOW_W-1:0] new_due;
   logic [CNT_W-1:0] cv;

   aert_ram #(.WIDTH(SW), .DEPTH(TABLE_SLOTS)) u_slots (
      .clock   (clock),
      .wr_en   (slot_we),
      .wr_addr (slot_waddr),
      .wr_data (slot_wdata),
      .rd_addr (slot_raddr),
      .rd_data (slot_rbits)
   );

   aert_ram #(.WIDTH(PW), .DEPTH(TABLE_SLOTS)) u_pkts (
      .clock   (clock),
      .wr_en   (pkt_we),
      .wr_addr (pkt_cnt_ff[IW-1:0]),
      .wr_data (pkt_wdata),
      .rd_addr (emit_idx_ff[IW-1:0]),
      .rd_data (pkt_rbits)
   );

   assign slot_rdata = slot_type'(slot_rbits);
   assign pkt_rdata  = pkt_type'(pkt_rbits);
   assign slot_raddr = scan_ff[IW-1:0];

   // First free slot in index order.
   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_any = 1'b1;
            free_idx = IW'(i);
         end
      end
   end

   assign nr      = slot_rdata.retries + 1'b1;
   assign ridx    = (nr > TOP_IDX) ? TOP_IDX : nr;
   assign new_due = due_after(job_ff.now, delay_ms(ridx));
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pend_ext = (CW + 4)'(pend_ff);

   always_comb begin
      case (job_ff.sel)
         CNT_FULL:    cv = err_ff[0];
         CNT_RETRY:   cv = err_ff[1];
         CNT_SENDERR: cv = err_ff[2];
         CNT_UNCONF:  cv = err_ff[3];
         CNT_SEQEX:   cv = err_ff[4];
         default:     cv = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      used_in      = used_ff;
      next_seq_in  = next_seq_ff;
      seq_done_in  = seq_done_ff;
      lvl_valid_in = lvl_valid_ff;
      lvl_in       = lvl_ff;
      bump         = '0;
      scan_in      = scan_ff;
      proc_vld_in  = 1'b0;
      proc_idx_in  = proc_idx_ff;
      pend_in      = pend_ff;
      dl_in        = dl_ff;
      found_in     = found_ff;
      status_in    = status_ff;
      st_seq_in    = st_seq_ff;
      st_lvl_in    = st_lvl_ff;
      pkt_cnt_in   = pkt_cnt_ff;
      emit_idx_in  = emit_idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      pop          = 1'b0;
      slot_we      = 1'b0;
      slot_waddr   = proc_idx_ff;
      slot_wdata   = slot_rdata;
      pkt_we       = 1'b0;
      pkt_wdata    = '{level: slot_rdata.level, seq: slot_rdata.seq};

      // Result of the slot read issued in the previous cycle.
      if (proc_vld_ff) begin
         if (used_ff[proc_idx_ff]) begin
            if (job_ff.op == OP_TICK && job_ff.now >= slot_rdata.due) begin
               if (slot_rdata.retries >= LIMIT) begin
                  used_in[proc_idx_ff] = 1'b0;
                  bump[CNT_RETRY]      = 1'b1;
               end else begin
                  if (link_ready) begin
                     pkt_we     = 1'b1;
                     pkt_cnt_in = pkt_cnt_ff + 1'b1;
                  end else begin
                     bump[CNT_UNCONF] = 1'b1;
                  end
                  slot_we            = 1'b1;
                  slot_wdata.due     = new_due;
                  slot_wdata.retries = nr;
                  pend_in            = pend_ff + 1'b1;
                  if (new_due < dl_ff) begin
                     dl_in = new_due;
                  end
               end
            end else if (job_ff.op == OP_ACK && !found_ff &&
                         slot_rdata.seq == job_ff.ack_seq) begin
               used_in[proc_idx_ff] = 1'b0;
               found_in             = 1'b1;
               status_in            = RS_ACK_MATCH;
            end else begin
               pend_in = pend_ff + 1'b1;
               if (slot_rdata.due < dl_ff) begin
                  dl_in = slot_rdata.due;
               end
            end
         end
      end

      case (state_ff)
         S_IDLE: begin
            if (!q_empty) begin
               pop         = 1'b1;
               job_in      = q_job;
               // The packet buffer of a new item starts at entry zero.
               pkt_cnt_in  = '0;
               emit_idx_in = '0;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            scan_in     = '0;
            pend_in     = '0;
            dl_in       = NOW_MAX;
            found_in    = 1'b0;
            emit_idx_in = '0;
            pkt_cnt_in  = '0;
            st_seq_in   = '0;
            st_lvl_in   = 1'b0;
            state_in    = S_SCAN;
            case (job_ff.op)
               OP_SUBMIT: begin
                  lvl_valid_in = 1'b1;
                  lvl_in       = job_ff.level;
                  if (!free_any) begin
                     bump[CNT_FULL] = 1'b1;
                     status_in      = RS_FULL;
                  end else if (seq_done_ff) begin
                     bump[CNT_SEQEX] = 1'b1;
                     status_in       = RS_SEQ_EXH;
                  end else begin
                     if (next_seq_ff == SEQ_MAX) begin
                        seq_done_in = 1'b1;
                     end else begin
                        next_seq_in = next_seq_ff + 1'b1;
                     end
                     used_in[free_idx] = 1'b1;
                     slot_we    = 1'b1;
                     slot_waddr = free_idx;
                     slot_wdata = '{seq: next_seq_ff, level: job_ff.level,
                                    due: due_after(job_ff.now, delay_ms('0)),
                                    retries: '0};
                     pkt_wdata  = '{level: job_ff.level, seq: next_seq_ff};
                     if (link_ready) begin
                        pkt_we     = 1'b1;
                        pkt_cnt_in = CW'(1);
                     end else begin
                        bump[CNT_UNCONF] = 1'b1;
                     end
                     status_in = RS_OK;
                     st_seq_in = next_seq_ff;
                     st_lvl_in = job_ff.level;
                  end
               end
               OP_TICK:       status_in = RS_DONE;
               OP_ACK:        status_in = RS_ACK_MISS;
               OP_ACK_NOBOOT: status_in = RS_ACK_MISS;
               OP_CLEAR: begin
                  used_in   = '0;
                  status_in = RS_DONE;
               end
               OP_SENDERR: begin
                  bump[CNT_SENDERR] = 1'b1;
                  status_in         = RS_DONE;
               end
               default:       status_in = RS_INVALID;
            endcase
         end
         S_SCAN: begin
            if (scan_ff < CW'(TABLE_SLOTS)) begin
               proc_vld_in = 1'b1;
               proc_idx_in = scan_ff[IW-1:0];
               scan_in     = scan_ff + 1'b1;
            end else if (!proc_vld_ff) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (emit_idx_ff == pkt_cnt_ff) begin
               if (out_free) begin
                  rsp_valid_in           = 1'b1;
                  rsp_in.is_packet       = 1'b0;
                  rsp_in.packet_sequence = st_seq_ff;
                  rsp_in.packet_level    = st_lvl_ff;
                  rsp_in.status          = status_ff;
                  rsp_in.last            = 1'b1;
                  rsp_in.pending_count   = pend_ext[3:0];
                  rsp_in.next_deadline   = dl_ff;
                  rsp_in.level_valid     = lvl_valid_ff;
                  rsp_in.level_now       = lvl_ff;
                  rsp_in.counter_value   = cv;
                  state_in               = S_IDLE;
               end
            end else begin
               state_in = S_WAITRD;
            end
         end
         S_WAITRD: state_in = S_LOAD;
         S_LOAD: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.is_packet       = 1'b1;
               rsp_in.packet_sequence = pkt_rdata.seq;
               rsp_in.packet_level    = pkt_rdata.level;
               rsp_in.status          = RS_OK;
               rsp_in.last            = 1'b0;
               rsp_in.pending_count   = pend_ext[3:0];
               rsp_in.next_deadline   = dl_ff;
               rsp_in.level_valid     = lvl_valid_ff;
               rsp_in.level_now       = lvl_ff;
               rsp_in.counter_value   = cv;
               emit_idx_in            = emit_idx_ff + 1'b1;
               state_in               = S_EMIT;
            end
         end
         default: state_in = S_IDLE;
      endcase

      for (int k = 0; k < NUM_CNT; k++) begin
         err_in[k] = (bump[k] && err_ff[k] != '1) ? err_ff[k] + 1'b1 : err_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         next_seq_ff  <= SEQ_FIRST;
         seq_done_ff  <= 1'b0;
         lvl_valid_ff <= 1'b0;
         lvl_ff       <= 1'b0;
         for (int k = 0; k < NUM_CNT; k++) begin
            err_ff[k] <= '0;
         end
         scan_ff      <= '0;
         proc_vld_ff  <= 1'b0;
         pkt_cnt_ff   <= '0;
         emit_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         next_seq_ff  <= next_seq_in;
         seq_done_ff  <= seq_done_in;
         lvl_valid_ff <= lvl_valid_in;
         lvl_ff       <= lvl_in;
         for (int k = 0; k < NUM_CNT; k++) begin
            err_ff[k] <= err_in[k];
         end
         scan_ff      <= scan_in;
         proc_vld_ff  <= proc_vld_in;
         pkt_cnt_ff   <= pkt_cnt_in;
         emit_idx_ff  <= emit_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff      <= job_in;
      proc_idx_ff <= proc_idx_in;
      pend_ff     <= pend_in;
      dl_ff       <= dl_in;
      found_ff    <= found_in;
      status_ff   <= status_in;
      st_seq_ff   <= st_seq_in;
      st_lvl_ff   <= st_lvl_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   `AERT_IMPLY(a_idle_drained, state_ff == S_IDLE, emit_idx_ff == pkt_cnt_ff,
               "item left with packets not delivered")
   `AERT_ASSERT(a_pkt_bound, pkt_cnt_ff <= CW'(TABLE_SLOTS),
                "more packets buffered than slots")
   `AERT_IMPLY(a_empty_deadline, state_ff == S_EMIT && pend_ff == '0, dl_ff == NOW_MAX,
               "deadline set with no pending slot")

endmodule

`default_nettype wire

>>> hdl/acked_event_retry_table.sv
// Channel   Direction  Handshake                Payload
// req_      in         req_tvalid/req_tready    tuser: cmd; tdata: event fields, time, ack
// rsp_      out        rsp_tvalid/rsp_tready    tuser: is_packet; tdata: result; tlast: last
// csr_      in         csr_we (no wait)         csr_addr, csr_wdata
//
// The back takes one item at a time: it reads every slot record in turn from the
// slot memory, then emits each transmitted packet and then the item's result.
// A two-item queue lets the front accept items while the back is busy.
// The output register holds a result until rsp_tready; the next result waits meanwhile.
// Synchronous reset empties the table and resets counters; no clearing pass is needed.
`default_nettype none

module acked_event_retry_table
   import aert_pkg::*;
#(
   parameter int TABLE_SLOTS = TABLE_SLOTS_DEF,
   parameter int RETRY_LIMIT = RETRY_LIMIT_DEF
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   // cmd[2:0]
   input  wire logic [2:0]    req_tuser,
   // event_kind, event_level, now_ms[47:0], ack_boot_id[31:0], ack_sequence[31:0],
   // counter_select[2:0], zero fill
   input  wire logic [119:0]  req_tdata,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   // is_packet
   output logic               rsp_tuser,
   // packet_sequence[31:0], packet_level, status[2:0], pending_count[3:0],
   // next_deadline[47:0], level_valid, level_now, counter_value[31:0], zero fill
   output logic [127:0]       rsp_tdata,
   output logic               rsp_tlast,
   input  wire logic          csr_we,
   input  wire logic          csr_addr,
   input  wire logic [31:0]   csr_wdata
);

   logic [SEQ_W-1:0] boot_id_ff;
   logic             link_ready_ff;
   logic             pop, q_empty;
   job_type          q_job;
   rsp_type          rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         boot_id_ff    <= '0;
         link_ready_ff <= 1'b1;
      end else if (csr_we) begin
         case (csr_addr)
            REG_BOOT_ID:    boot_id_ff    <= csr_wdata;
            REG_LINK_READY: link_ready_ff <= csr_wdata[0];
            default:        boot_id_ff    <= boot_id_ff;
         endcase
      end
   end

   aert_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .cmd            (req_tuser),
      .event_kind     (req_tdata[0]),
      .event_level    (req_tdata[1]),
      .now_ms         (req_tdata[49:2]),
      .ack_boot_id    (req_tdata[81:50]),
      .ack_sequence   (req_tdata[113:82]),
      .counter_select (req_tdata[116:114]),
      .boot_id        (boot_id_ff),
      .pop            (pop),
      .empty          (q_empty),
      .job            (q_job)
   );

   aert_back #(
      .TABLE_SLOTS (TABLE_SLOTS),
      .RETRY_LIMIT (RETRY_LIMIT)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .link_ready (link_ready_ff),
      .q_empty    (q_empty),
      .q_job      (q_job),
      .pop        (pop),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp        (rsp)
   );

   assign rsp_tuser = rsp.is_packet;
   assign rsp_tlast = rsp.last;
   assign rsp_tdata = {6'd0, rsp.counter_value, rsp.level_now, rsp.level_valid,
                       rsp.next_deadline, rsp.pending_count, rsp.status,
                       rsp.packet_level, rsp.packet_sequence};

endmodule

`default_nettype wire

>>> tb/retry_table_checker.sv
module retry_table_checker
   import aert_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   input  wire logic          req_tready,
   input  wire logic [2:0]    req_tuser,
   input  wire logic [119:0]  req_tdata,
   input  wire logic          rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire logic          rsp_tuser,
   input  wire logic [127:0]  rsp_tdata,
   input  wire logic          rsp_tlast,
   input  wire logic          csr_we,
   input  wire logic          csr_addr,
   input  wire logic [31:0]   csr_wdata,
   output int                 fail_count,
   output int                 pending_results
);

   localparam int SLOTS = 8;
   localparam int RETRIES = 6;

   logic              used_q [SLOTS];
   logic [31:0]       seq_q [SLOTS];
   logic              lvl_q [SLOTS];
   logic [47:0]       due_q [SLOTS];
   logic [2:0]        tries_q [SLOTS];
   logic [31:0]       seq_next;
   logic              seq_spent;
   logic              have_level;
   logic              level_q;
   logic [31:0]       err_cnt [NUM_CNT];
   logic [31:0]       boot_q;
   logic              link_q;
   rsp_type           expected_rsp [$];

   assign pending_results = expected_rsp.size();

   function automatic logic [47:0] sat_due(logic [47:0] now, int unsigned dly);
      logic [48:0] s;
      s = {1'b0, now} + 49'(dly);
      return s[48] ? '1 : s[47:0];
   endfunction

   function automatic int unsigned retry_delay(int idx);
      return 250 << idx;
   endfunction

   task automatic bump(logic [2:0] which);
      if (err_cnt[which] != '1) err_cnt[which]++;
   endtask

   task automatic transmit(int s, ref rsp_type run [$]);
      rsp_type r;
      if (!link_q) begin
         bump(CNT_UNCONF);
         return;
      end
      r = '0;
      r.is_packet = 1'b1;
      r.packet_sequence = seq_q[s];
      r.packet_level = lvl_q[s];
      run.push_back(r);
   endtask

   task automatic predict_item(logic [2:0] cmd, logic [119:0] d);
      logic        kind, lvl;
      logic [47:0] now;
      logic [31:0] a_boot, a_seq;
      logic [2:0]  sel;
      rsp_type     run [$];
      rsp_type     r;
      logic [2:0]  st;
      logic [31:0] st_seq;
      logic        st_lvl;
      int          found, cnt, rr;
      logic [47:0] dl;
      kind = d[0]; lvl = d[1]; now = d[49:2];
      a_boot = d[81:50]; a_seq = d[113:82]; sel = d[116:114];
      st = RS_INVALID; st_seq = '0; st_lvl = 1'b0;
      case (cmd)
         CMD_SUBMIT: begin
            if (kind != lvl) begin
               have_level = 1'b1;
               level_q = lvl;
               found = SLOTS;
               for (int s = SLOTS - 1; s >= 0; s--) if (!used_q[s]) found = s;
               if (found == SLOTS) begin
                  bump(CNT_FULL);
                  st = RS_FULL;
               end else if (seq_spent) begin
                  bump(CNT_SEQEX);
                  st = RS_SEQ_EXH;
               end else begin
                  st_seq = seq_next;
                  if (seq_next == '1) seq_spent = 1'b1;
                  else seq_next++;
                  used_q[found] = 1'b1;
                  seq_q[found] = st_seq;
                  lvl_q[found] = lvl;
                  due_q[found] = sat_due(now, retry_delay(0));
                  tries_q[found] = '0;
                  transmit(found, run);
                  st = RS_OK;
                  st_lvl = lvl;
               end
            end
         end
         CMD_TICK: begin
            for (int s = 0; s < SLOTS; s++) begin
               if (!used_q[s] || now < due_q[s]) continue;
               if (tries_q[s] >= RETRIES) begin
                  used_q[s] = 1'b0;
                  bump(CNT_RETRY);
                  continue;
               end
               transmit(s, run);
               tries_q[s]++;
               rr = (tries_q[s] > 5) ? 5 : tries_q[s];
               due_q[s] = sat_due(now, retry_delay(rr));
            end
            st = RS_DONE;
         end
         CMD_ACK: begin
            st = RS_ACK_MISS;
            if (a_boot == boot_q) begin
               for (int s = 0; s < SLOTS; s++) begin
                  if (used_q[s] && seq_q[s] == a_seq) begin
                     used_q[s] = 1'b0;
                     st = RS_ACK_MATCH;
                     break;
                  end
               end
            end
         end
         CMD_CLEAR: begin
            for (int s = 0; s < SLOTS; s++) used_q[s] = 1'b0;
            st = RS_DONE;
         end
         CMD_SENDERR: begin
            bump(CNT_SENDERR);
            st = RS_DONE;
         end
         default: st = RS_INVALID;
      endcase
      r = '0;
      r.packet_sequence = st_seq;
      r.packet_level = st_lvl;
      r.status = st;
      r.last = 1'b1;
      run.push_back(r);
      cnt = 0;
      dl = '1;
      for (int s = 0; s < SLOTS; s++) begin
         if (used_q[s]) begin
            cnt++;
            if (due_q[s] < dl) dl = due_q[s];
         end
      end
      foreach (run[k]) begin
         r = run[k];
         r.pending_count = 4'(cnt);
         r.next_deadline = dl;
         r.level_valid = have_level;
         r.level_now = level_q;
         r.counter_value = (sel < NUM_CNT) ? err_cnt[sel] : '0;
         expected_rsp.push_back(r);
      end
   endtask

   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type e;
      rsp_type a;
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            used_q[s] <= 1'b0; seq_q[s] <= '0; lvl_q[s] <= 1'b0;
            due_q[s] <= '0; tries_q[s] <= '0;
         end
         for (int c = 0; c < NUM_CNT; c++) err_cnt[c] <= '0;
         seq_next <= SEQ_FIRST;
         seq_spent <= 1'b0;
         have_level <= 1'b0;
         level_q <= 1'b0;
         boot_q <= '0;
         link_q <= 1'b1;
         expected_rsp.delete();
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            if (csr_addr == REG_BOOT_ID) boot_q = csr_wdata;
            else link_q = csr_wdata[0];
         end
         if (req_tvalid && req_tready) predict_item(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) begin
            a = {rsp_tuser, rsp_tdata[31:0], rsp_tdata[32], rsp_tdata[35:33],
                 rsp_tdata[39:36], rsp_tdata[87:40], rsp_tdata[88], rsp_tdata[89],
                 rsp_tdata[121:90], rsp_tlast};
            if (expected_rsp.size() == 0) begin
               $error("unexpected result item: %h", a);
               fail_count++;
            end else begin
               e = expected_rsp.pop_front();
               check_field("is_packet", e.is_packet, a.is_packet);
               check_field("packet_sequence", e.packet_sequence, a.packet_sequence);
               check_field("packet_level", e.packet_level, a.packet_level);
               check_field("status", e.status, a.status);
               check_field("pending_count", e.pending_count, a.pending_count);
               check_field("next_deadline", e.next_deadline, a.next_deadline);
               check_field("level_valid", e.level_valid, a.level_valid);
               check_field("level_now", e.level_now, a.level_now);
               check_field("counter_value", e.counter_value, a.counter_value);
               check_field("last", e.last, a.last);
            end
         end
      end
   end

endmodule

>>> tb/tb_top.sv
module tb_top;
   import aert_pkg::*;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [2:0]    req_tuser = '0;
   logic [119:0]  req_tdata = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic          rsp_tuser;
   logic [127:0]  rsp_tdata;
   logic          rsp_tlast;
   logic          csr_we = 1'b0;
   logic          csr_addr = 1'b0;
   logic [31:0]   csr_wdata = '0;
   int            fail_count;
   int            pending_results;
   int            send_idle_pct;
   int            stall_pct;
   logic [47:0]   clock_ms;
   logic [31:0]   cur_boot;
   logic [31:0]   last_seq;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   acked_event_retry_table i_dut (.*);

   retry_table_checker i_checker (.*);

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // tvalid stays high between items sent back to back; idle gaps and
   // drain_results take it low.
   task automatic send_item(logic [2:0] cmd, logic kind, logic lvl, logic [47:0] now,
                            logic [31:0] a_boot, logic [31:0] a_seq, logic [2:0] sel);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {3'b0, sel, a_seq, a_boot, now, lvl, kind};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_results != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_reg(logic addr, logic [31:0] value);
      drain_results();
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_item();
      int pick;
      logic k;
      pick = $urandom_range(99);
      k = 1'($urandom_range(1));
      if (pick < 40) begin
         clock_ms += 48'($urandom_range(50));
         send_item(CMD_SUBMIT, k, ($urandom_range(9) == 0) ? k : ~k, clock_ms,
                   $urandom, $urandom, 3'($urandom_range(7)));
      end else if (pick < 70) begin
         clock_ms += 48'($urandom_range(3000));
         send_item(CMD_TICK, k, 1'($urandom_range(1)), clock_ms, $urandom, $urandom,
                   3'($urandom_range(7)));
      end else if (pick < 88) begin
         send_item(CMD_ACK, k, 1'($urandom_range(1)), 48'($urandom),
                   ($urandom_range(7) == 0) ? $urandom : cur_boot,
                   last_seq - $urandom_range(10), 3'($urandom_range(7)));
      end else if (pick < 92) begin
         send_item(CMD_CLEAR, k, 1'($urandom_range(1)), 48'($urandom), $urandom, $urandom,
                   3'($urandom_range(7)));
      end else begin
         send_item(3'($urandom_range(4, 7)), k, 1'($urandom_range(1)),
                   48'({$urandom, $urandom}), $urandom, $urandom, 3'($urandom_range(7)));
      end
      last_seq++;
   endtask

   initial begin
      send_idle_pct = 0;
      stall_pct = 0;
      clock_ms = 48'd1000;
      cur_boot = 32'h0;
      last_seq = 32'd1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: invalid events, fill to overflow, acks, ticks, odd commands.
      send_item(CMD_SUBMIT, KIND_DETECTED, 1'b0, '0, '0, '0, CNT_FULL);
      send_item(CMD_SUBMIT, KIND_CLEARED, 1'b1, '1, '1, '1, 3'd7);
      for (int i = 0; i < 9; i++)
         send_item(CMD_SUBMIT, 1'(i), ~1'(i), (i == 8) ? 48'hFFFF_FFFF_FF00 : 48'(i),
                   '0, '0, CNT_FULL);
      send_item(CMD_ACK, 1'b0, 1'b0, '0, '0, 32'd3, CNT_FULL);
      send_item(CMD_ACK, 1'b0, 1'b0, '0, '1, 32'd4, CNT_FULL);
      send_item(CMD_TICK, 1'b0, 1'b0, 48'd300, '0, '0, CNT_RETRY);
      for (int i = 0; i < 7; i++)
         send_item(CMD_TICK, 1'b0, 1'b0, 48'd20000 * (i + 1), '0, '0, CNT_RETRY);
      send_item(CMD_SENDERR, 1'b0, 1'b0, '0, '0, '0, CNT_SENDERR);
      send_item(3'd7, 1'b1, 1'b1, '1, '1, '1, 3'd5);
      send_item(CMD_CLEAR, 1'b0, 1'b0, '0, '0, '0, CNT_UNCONF);

      // Pause until the table is quiet, then run with the link down.
      write_reg(REG_LINK_READY, 32'd0);
      send_item(CMD_SUBMIT, KIND_DETECTED, 1'b1, 48'd10, '0, '0, CNT_UNCONF);
      send_item(CMD_TICK, 1'b0, 1'b0, 48'd5000, '0, '0, CNT_UNCONF);
      write_reg(REG_LINK_READY, 32'd1);
      write_reg(REG_BOOT_ID, 32'hFFFF_FFFF);
      cur_boot = 32'hFFFF_FFFF;
      send_item(CMD_ACK, 1'b0, 1'b0, '0, '1, 32'd10, CNT_SEQEX);
      last_seq = 32'd11;

      for (int phase = 0; phase < 4; phase++) begin
         send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 3) ? 29 : 59) : 0;
         stall_pct = (phase == 2 || phase == 3) ? ((phase == 3) ? 29 : 59) : 0;
         for (int i = 0; i < 50; i++) random_item();
         if (phase == 1) begin
            write_reg(REG_BOOT_ID, $urandom);
            cur_boot = $urandom;
            write_reg(REG_BOOT_ID, cur_boot);
            write_reg(REG_LINK_READY, 32'd0);
            for (int i = 0; i < 5; i++) random_item();
            write_reg(REG_LINK_READY, 32'd1);
         end
      end

      drain_results();
      if (fail_count == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> acked_event_retry_table.f
+incdir+hdl
hdl/aert_pkg.sv
hdl/aert_ram.sv
hdl/aert_front.sv
hdl/aert_back.sv
hdl/acked_event_retry_table.sv
tb/retry_table_checker.sv
tb/tb_top.sv
